// ----- hdl/rmvg_pkg.sv -----
// rmvg_pkg: shared types and constants for the ROI mean/variance gate.
// Used by every module of the block but rmvg_div and rmvg_checker; depends on nothing.

package rmvg_pkg;

	// Fixed field and accumulator widths
	localparam int PIX_W  = 16;
	localparam int SUM_W  = 36;
	localparam int SQ_W   = 52;
	localparam int LIM_W  = 16;
	localparam int FW_W   = 11;
	localparam int POS_W  = 10;
	localparam int SIZE_W = 11;
	localparam int IDX_W  = 3;
	localparam int CFG_W  = 16;

	// Register indexes on the configuration channel
	localparam logic [IDX_W-1:0] REG_ROW_LEN     = 3'd0;
	localparam logic [IDX_W-1:0] REG_ROI_LEFT    = 3'd1;
	localparam logic [IDX_W-1:0] REG_ROI_TOP     = 3'd2;
	localparam logic [IDX_W-1:0] REG_ROI_COLS    = 3'd3;
	localparam logic [IDX_W-1:0] REG_ROI_ROWS    = 3'd4;
	localparam logic [IDX_W-1:0] REG_DEV_LIMIT   = 3'd5;

	// Reset values of the registers
	localparam logic [FW_W-1:0]   RST_ROW_LEN     = 11'd80;
	localparam logic [POS_W-1:0]  RST_ROI_LEFT    = 10'd10;
	localparam logic [POS_W-1:0]  RST_ROI_TOP     = 10'd25;
	localparam logic [SIZE_W-1:0] RST_ROI_COLS    = 11'd60;
	localparam logic [SIZE_W-1:0] RST_ROI_ROWS    = 11'd10;
	localparam logic [LIM_W-1:0]  RST_DEV_LIMIT   = 16'd12;

	typedef struct packed {
		logic [FW_W-1:0]   row_len;
		logic [POS_W-1:0]  roi_left;
		logic [POS_W-1:0]  roi_top;
		logic [SIZE_W-1:0] roi_cols;
		logic [SIZE_W-1:0] roi_rows;
		logic [LIM_W-1:0]  deviation_limit;
	} cfg_regs_t;

	typedef enum logic [3:0] {
		ST_RUN,
		ST_DRAIN,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_MEAN,
		ST_MUL_A,
		ST_MUL_B,
		ST_SUM,
		ST_OUT
	} ctrl_state_t;

	typedef struct packed {
		logic in_ready;
		logic load_dims;
		logic div_start;
		logic load_mean;
		logic mul_a;
		logic mul_b;
		logic sum;
		logic load_out;
		logic clear_sums;
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_free;
	} dp_sts_t;

endpackage

// ----- hdl/rmvg_cfg.sv -----
// rmvg_cfg: configuration register file written over the cfg channel.
// Depends on rmvg_pkg.

module rmvg_cfg import rmvg_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	output cfg_regs_t        regs
);

	cfg_regs_t regs_q;

	assign cfg_ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.row_len         <= RST_ROW_LEN;
			regs_q.roi_left        <= RST_ROI_LEFT;
			regs_q.roi_top         <= RST_ROI_TOP;
			regs_q.roi_cols        <= RST_ROI_COLS;
			regs_q.roi_rows        <= RST_ROI_ROWS;
			regs_q.deviation_limit <= RST_DEV_LIMIT;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ROW_LEN:     regs_q.row_len         <= cfg_data[FW_W-1:0];
				REG_ROI_LEFT:    regs_q.roi_left        <= cfg_data[POS_W-1:0];
				REG_ROI_TOP:     regs_q.roi_top         <= cfg_data[POS_W-1:0];
				REG_ROI_COLS:    regs_q.roi_cols        <= cfg_data[SIZE_W-1:0];
				REG_ROI_ROWS:    regs_q.roi_rows        <= cfg_data[SIZE_W-1:0];
				REG_DEV_LIMIT:   regs_q.deviation_limit <= cfg_data[LIM_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// ----- hdl/rmvg_div.sv -----
// rmvg_div: restoring divider, one quotient bit per cycle.
// Standalone; used by rmvg_dp for the frame mean.

module rmvg_div #(
	parameter int DEND_W = 36,
	parameter int DSOR_W = 22
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DEND_W-1:0] dividend,
	input  logic [DSOR_W-1:0] divisor,
	output logic [DEND_W-1:0] quotient,
	output logic              done
);

	localparam int CNT_W = $clog2(DEND_W + 1);

	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic [DSOR_W-1:0] rem_q;
	logic [DSOR_W-1:0] dsor_q;
	logic [DEND_W-1:0] quo_q;
	logic [DSOR_W:0]   shifted;
	logic [DSOR_W:0]   diff;
	logic              fits;

	always_comb begin
		shifted = {rem_q, quo_q[DEND_W-1]};
		diff    = shifted - {1'b0, dsor_q};
		fits    = shifted >= {1'b0, dsor_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(DEND_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - CNT_W'(1);
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quo_q  <= dividend;
			dsor_q <= divisor;
		end else if (cnt_q != '0) begin
			// remainder always stays below the divisor when the divisor is nonzero
			rem_q <= fits ? diff[DSOR_W-1:0] : shifted[DSOR_W-1:0];
			quo_q <= {quo_q[DEND_W-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

// ----- hdl/rmvg_dp.sv -----
// rmvg_dp: datapath - pixel locator, ROI accumulators, mean divider,
// exact variance test and output register. Depends on rmvg_pkg, rmvg_div.

module rmvg_dp import rmvg_pkg::*; #(
	parameter int MAX_DIM    = 1024,
	parameter int PIXEL_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  dp_cmd_t          cmd,
	output dp_sts_t          sts,
	input  cfg_regs_t        regs,
	input  logic             in_valid,
	input  logic [PIX_W-1:0] pixel,
	input  logic             frame_end,
	input  logic             out_ready,
	output logic             out_valid,
	output logic [PIX_W-1:0] avg_reading,
	output logic             rejected,
	output logic [PIX_W-1:0] raw_mean
);

	localparam int CNT_W = $clog2(MAX_DIM);
	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam int CMP_W = ((DIM_W > POS_W) ? DIM_W : POS_W) + 1;
	localparam int N_W   = 2 * DIM_W;
	localparam int SQP_W = 2 * PIXEL_BITS;
	localparam int LL_W  = 2 * LIM_W;
	localparam int T1_W  = N_W + PIXEL_BITS;
	localparam int P1_W  = N_W + 2 * PIXEL_BITS;
	localparam int P2_W  = SUM_W + PIXEL_BITS;
	localparam int P3_W  = N_W + LL_W;
	localparam int LA_W  = (P1_W > SQ_W) ? P1_W : SQ_W;
	localparam int LB_W  = ((P2_W + 1) > P3_W) ? (P2_W + 1) : P3_W;
	localparam int LR_W  = ((LA_W > LB_W) ? LA_W : LB_W) + 1;
	localparam logic [PIXEL_BITS-1:0] PIX_MAX = '1;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [SIZE_W-1:0] v);
		if (v == '0)
			clamp_dim = DIM_W'(1);
		else if (32'(v) > MAX_DIM)
			clamp_dim = DIM_W'(MAX_DIM);
		else
			clamp_dim = DIM_W'(v);
	endfunction

	logic [DIM_W-1:0] fw, cols, rows;
	logic             accept, in_roi, col_wrap;
	logic [CMP_W-1:0] col_x, row_x, left_x, top_x;
	logic [PIXEL_BITS-1:0] pix_m;

	logic [CNT_W-1:0] col_q, row_q;
	logic                  acc_s1;
	logic [PIXEL_BITS-1:0] pix_s1;
	logic [SQP_W-1:0]      sq_s1;
	logic [SUM_W-1:0]      sum_q;
	logic [SQ_W-1:0]       sq_q;
	logic [SUM_W:0]        sum_ext;
	logic [SQ_W:0]         sq_ext;

	logic [N_W-1:0]        n_q;
	logic [LL_W-1:0]       ll_q;
	logic [SUM_W-1:0]      quo;
	logic                  div_done;
	logic [PIXEL_BITS-1:0] a_q;
	logic [T1_W-1:0]       t1_q;
	logic [P1_W-1:0]       p1_q;
	logic [P2_W-1:0]       p2_q;
	logic [P3_W-1:0]       p3_q;
	logic [LR_W-1:0]       lhs_q, rhs_q;
	logic                  rej_c;

	logic             out_valid_q;
	logic [PIX_W-1:0] avg_q, raw_q;
	logic             rej_q;

	// Pixel locator and ROI test
	always_comb begin
		fw       = clamp_dim(regs.row_len);
		cols     = clamp_dim(regs.roi_cols);
		rows     = clamp_dim(regs.roi_rows);
		accept   = in_valid & cmd.in_ready;
		pix_m    = pixel[PIXEL_BITS-1:0];
		col_x    = CMP_W'(col_q);
		row_x    = CMP_W'(row_q);
		left_x   = CMP_W'(regs.roi_left);
		top_x    = CMP_W'(regs.roi_top);
		in_roi   = (col_x >= left_x) && (col_x < left_x + CMP_W'(cols)) &&
		           (row_x >= top_x) && (row_x < top_x + CMP_W'(rows));
		col_wrap = ((DIM_W + 1)'(col_q) + (DIM_W + 1)'(1)) >= (DIM_W + 1)'(fw);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (frame_end) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_wrap) begin
				col_q <= '0;
				// row counter sticks at the last row
				if (row_q != CNT_W'(MAX_DIM - 1))
					row_q <= row_q + CNT_W'(1);
			end else begin
				col_q <= col_q + CNT_W'(1);
			end
		end
	end

	// Stage 1: square the pixel; stage 2: saturating accumulate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			acc_s1 <= 1'b0;
		else
			acc_s1 <= accept & in_roi;
	end

	always_ff @(posedge clk) begin
		pix_s1 <= pix_m;
		sq_s1  <= SQP_W'(pix_m) * SQP_W'(pix_m);
	end

	always_comb begin
		sum_ext = {1'b0, sum_q} + (SUM_W + 1)'(pix_s1);
		sq_ext  = {1'b0, sq_q} + (SQ_W + 1)'(sq_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			sq_q  <= '0;
		end else if (cmd.clear_sums) begin
			sum_q <= '0;
			sq_q  <= '0;
		end else if (acc_s1) begin
			sum_q <= sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
			sq_q  <= sq_ext[SQ_W] ? '1 : sq_ext[SQ_W-1:0];
		end
	end

	// Frame-end arithmetic
	rmvg_div #(
		.DEND_W (SUM_W),
		.DSOR_W (N_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sum_q),
		.divisor  (n_q),
		.quotient (quo),
		.done     (div_done)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_dims) begin
			n_q  <= N_W'(cols) * N_W'(rows);
			ll_q <= LL_W'(regs.deviation_limit) * LL_W'(regs.deviation_limit);
		end
		if (cmd.load_mean)
			a_q <= (|quo[SUM_W-1:PIXEL_BITS]) ? PIX_MAX : quo[PIXEL_BITS-1:0];
		if (cmd.mul_a) begin
			t1_q <= T1_W'(n_q) * T1_W'(a_q);
			p2_q <= P2_W'(a_q) * P2_W'(sum_q);
			p3_q <= P3_W'(ll_q) * P3_W'(n_q);
		end
		if (cmd.mul_b)
			p1_q <= P1_W'(t1_q) * P1_W'(a_q);
		// N*a*a + Q against 2*a*S + N*L*L
		if (cmd.sum) begin
			lhs_q <= LR_W'(p1_q) + LR_W'(sq_q);
			rhs_q <= (LR_W'(p2_q) << 1) + LR_W'(p3_q);
		end
	end

	assign rej_c = lhs_q > rhs_q;

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load_out)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			avg_q <= rej_c ? '0 : PIX_W'(a_q);
			rej_q <= rej_c;
			raw_q <= PIX_W'(a_q);
		end
	end

	assign sts.div_done = div_done;
	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign avg_reading  = avg_q;
	assign rejected     = rej_q;
	assign raw_mean     = raw_q;

endmodule

// ----- hdl/rmvg_ctrl.sv -----
// rmvg_ctrl: controller sequencing pixel intake and the frame-end steps.
// Depends on rmvg_pkg; drives rmvg_dp through dp_cmd_t.

module rmvg_ctrl import rmvg_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    in_last,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_RUN;
		else
			state_q <= state_d;
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_RUN: begin
				cmd.in_ready = 1'b1;
				if (in_valid && in_last)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				// last pixel is being added to the sums this cycle
				cmd.load_dims = 1'b1;
				state_d       = ST_DIV_GO;
			end
			ST_DIV_GO: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (sts.div_done)
					state_d = ST_MEAN;
			end
			ST_MEAN: begin
				cmd.load_mean = 1'b1;
				state_d       = ST_MUL_A;
			end
			ST_MUL_A: begin
				cmd.mul_a = 1'b1;
				state_d   = ST_MUL_B;
			end
			ST_MUL_B: begin
				cmd.mul_b = 1'b1;
				state_d   = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.load_out   = 1'b1;
					cmd.clear_sums = 1'b1;
					state_d        = ST_RUN;
				end
			end
			default: state_d = ST_RUN;
		endcase
	end

endmodule

// ----- hdl/roi_mean_variance_gate_unit.sv -----
// roi_mean_variance_gate_unit: top level of the ROI mean/variance gate.
// Depends on rmvg_pkg, rmvg_cfg, rmvg_ctrl, rmvg_dp (and rmvg_div below it).
//
//  channel  direction  payload
//  s_axis   in         tdata[15:0] pixel, tlast frame_end
//  m_axis   out        tdata[15:0] avg_reading, [31:16] raw_mean; tuser rejected
//  cfg      in         cfg_index register number, cfg_data value
//
// Pixels are taken one per cycle while a frame streams in.
// After the frame_end transfer the input stalls through the drain step, the
// one-bit-per-cycle mean divider and the multiply and compare steps.
// The result sits in an output register; intake resumes while it waits, and only
// the next frame's end stalls until it has been taken.
// Reset (arst_n low) clears counters, sums and the sequencer; no clearing pass.

module roi_mean_variance_gate_unit import rmvg_pkg::*; #(
	parameter int MAX_DIM    = 1024,
	parameter int PIXEL_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [15:0]      s_axis_tdata,  // [15:0] pixel
	input  logic             s_axis_tlast,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [31:0]      m_axis_tdata,  // [15:0] avg_reading, [31:16] raw_mean
	output logic             m_axis_tuser,  // [0] rejected
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	cfg_regs_t        regs;
	dp_cmd_t          cmd;
	dp_sts_t          sts;
	logic [PIX_W-1:0] avg_reading, raw_mean;

	rmvg_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	rmvg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_last  (s_axis_tlast),
		.sts      (sts),
		.cmd      (cmd)
	);

	rmvg_dp #(
		.MAX_DIM    (MAX_DIM),
		.PIXEL_BITS (PIXEL_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.regs        (regs),
		.in_valid    (s_axis_tvalid),
		.pixel       (s_axis_tdata),
		.frame_end   (s_axis_tlast),
		.out_ready   (m_axis_tready),
		.out_valid   (m_axis_tvalid),
		.avg_reading (avg_reading),
		.rejected    (m_axis_tuser),
		.raw_mean    (raw_mean)
	);

	assign s_axis_tready = cmd.in_ready;
	assign m_axis_tdata  = {raw_mean, avg_reading};

endmodule

// ----- hdl/rmvg_checker.sv -----
// rmvg_checker: port-level assertions for roi_mean_variance_gate_unit.
// Standalone; bound to the top level at the end of this file.

module rmvg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        s_axis_tlast,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic        m_axis_tuser
);

	// a frame-end transfer stalls intake while the result is worked out
	a_stall_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
		else $error("input still ready after frame-end transfer");

	// a new result only appears out of a stalled-input cycle
	a_result_from_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(s_axis_tready))
		else $error("result appeared without frame-end processing");

	a_rejected_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[15:0] == 16'd0)
		else $error("rejected reading not forced to zero");

	a_accepted_mean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[15:0] == m_axis_tdata[31:16])
		else $error("accepted reading differs from raw mean");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result changed");

endmodule

bind roi_mean_variance_gate_unit rmvg_checker u_rmvg_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// tb_top: self-checking bench for roi_mean_variance_gate_unit. Streams pixel frames under
// random source gaps and sink stalls; checks every frame reading against a local ROI model or a scripted value.
// Depends on rmvg_pkg and the block's RTL.

module tb_top;
	import rmvg_pkg::*;

	// indexes the block has no register behind; writes to them must change nothing
	localparam logic [IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [IDX_W-1:0] REG_SPARE_7 = 3'd7;

	localparam int          DIM_MAX    = 1024;
	localparam logic [63:0] SUM_CAP    = (64'd1 << SUM_W) - 64'd1;
	localparam logic [63:0] SQ_CAP     = (64'd1 << SQ_W) - 64'd1;
	localparam logic [63:0] MEAN_CAP   = (64'd1 << PIX_W) - 64'd1;
	localparam int          SETTLE     = 64;       // covers the whole frame-end sequence

	typedef struct packed {
		logic [15:0] avg;
		logic        rejected;
		logic [15:0] raw;
	} reading_t;

	typedef enum logic {ROW_REG, ROW_PIX} row_kind_t;

	typedef struct {
		row_kind_t        kind;
		logic [IDX_W-1:0] idx;
		logic [CFG_W-1:0] data;
		logic [15:0]      pix;
		logic             last;
		bit               typed;
		reading_t         want;
	} row_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	logic [15:0]      s_axis_tdata;   // [15:0] pixel
	logic             s_axis_tlast;   // frame_end
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	logic [31:0]      m_axis_tdata;   // [15:0] avg_reading, [31:16] raw_mean
	logic             m_axis_tuser;   // [0] rejected
	logic             cfg_valid;
	logic             cfg_ready;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	// model of the block: registers, raster position and the two accumulators
	cfg_regs_t        regs;
	int unsigned      col_pos;
	int unsigned      row_pos;
	logic [SUM_W-1:0] acc_sum;
	logic [SQ_W-1:0]  acc_sq;
	reading_t         pending_readings[$];

	int  mismatches;
	int  readings_seen;
	int  rejects_seen;
	int  pix_sent;
	int  frames_sent;
	int  settings;
	bit  tx_steady;
	bit  rx_steady;

	roi_mean_variance_gate_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #10 clk = ~clk;

	initial begin
		#100_000_000;
		$display("[roi_mean_variance_gate_unit] ERROR");
		$finish;
	end

	function automatic int unsigned clamp_dim(int unsigned v);
		if (v < 1) return 1;
		if (v > DIM_MAX) return DIM_MAX;
		return v;
	endfunction

	// mostly short, now and then a long one
	function automatic int pause_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	// one time in ten the whole 16-bit data word is random, upper bits included
	function automatic logic [CFG_W-1:0] reg_value(int unsigned tame);
		logic [31:0] v;
		v = $urandom;
		return ($urandom_range(0, 9) == 0) ? v[CFG_W-1:0] : tame[CFG_W-1:0];
	endfunction

	function automatic row_t reg_row(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		row_t r;
		r.kind  = ROW_REG;
		r.idx   = idx;
		r.data  = data;
		r.pix   = '0;
		r.last  = 1'b0;
		r.typed = 1'b0;
		r.want  = '0;
		return r;
	endfunction

	function automatic row_t pix_row(logic [15:0] pix, logic last);
		row_t r;
		r       = reg_row(REG_ROW_LEN, '0);
		r.kind  = ROW_PIX;
		r.pix   = pix;
		r.last  = last;
		return r;
	endfunction

	function automatic row_t known_row(logic [15:0] pix, logic [15:0] avg, logic rej,
			logic [15:0] raw);
		row_t r;
		r       = pix_row(pix, 1'b1);
		r.typed = 1'b1;
		r.want  = '{avg: avg, rejected: rej, raw: raw};
		return r;
	endfunction

	// Advance the model by one accepted pixel; on frame end work out the reading.
	// Variance test kept unsigned: N*a*a + Q > 2*a*S + N*L*L.
	task automatic track_pixel(input logic [15:0] pix, input logic last, output bit fired,
			output reading_t r);
		int unsigned fw, cols, rows;
		logic [63:0] p, sq, s, q, n, a, lim, lhs, rhs;
		bit          hit, rej;
		fw   = clamp_dim(regs.row_len);
		cols = clamp_dim(regs.roi_cols);
		rows = clamp_dim(regs.roi_rows);
		p    = {48'd0, pix};
		hit  = col_pos >= regs.roi_left && col_pos < regs.roi_left + cols &&
			row_pos >= regs.roi_top && row_pos < regs.roi_top + rows;
		if (hit) begin
			sq = p * p;
			s  = acc_sum;
			q  = acc_sq;
			acc_sum = (SUM_CAP - s < p) ? SUM_CAP[SUM_W-1:0] : s[SUM_W-1:0] + p[SUM_W-1:0];
			acc_sq  = (SQ_CAP - q < sq) ? SQ_CAP[SQ_W-1:0] : q[SQ_W-1:0] + sq[SQ_W-1:0];
		end
		// row counter sticks at the last row instead of wrapping
		if (col_pos + 1 >= fw) begin
			col_pos = 0;
			if (row_pos < DIM_MAX - 1) row_pos++;
		end else begin
			col_pos++;
		end
		fired = last;
		r     = '0;
		if (last) begin
			s   = acc_sum;
			q   = acc_sq;
			n   = cols;
			n   = n * rows;
			a   = s / n;
			if (a > MEAN_CAP) a = MEAN_CAP;
			lim = regs.deviation_limit;
			lhs = n * a * a + q;
			rhs = 2 * a * s + n * lim * lim;
			rej = lhs > rhs;
			r.raw      = a[15:0];
			r.rejected = rej;
			r.avg      = rej ? 16'd0 : a[15:0];
			col_pos = 0;
			row_pos = 0;
			acc_sum = '0;
			acc_sq  = '0;
		end
	endtask

	// called and returns at a falling edge
	task automatic send_pixel(input logic [15:0] pix, input logic last, input bit typed,
			input reading_t want);
		bit       fired;
		reading_t r;
		int       g;
		g = tx_steady ? 0 : pause_len();
		if (g > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (g) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = pix;
		s_axis_tlast  = last;
		do @(posedge clk); while (!s_axis_tready);
		track_pixel(pix, last, fired, r);
		pix_sent++;
		if (fired) begin
			pending_readings.push_back(typed ? want : r);
			frames_sent++;
		end
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_ROW_LEN:     regs.row_len         = data[FW_W-1:0];
			REG_ROI_LEFT:    regs.roi_left        = data[POS_W-1:0];
			REG_ROI_TOP:     regs.roi_top         = data[POS_W-1:0];
			REG_ROI_COLS:    regs.roi_cols        = data[SIZE_W-1:0];
			REG_ROI_ROWS:    regs.roi_rows        = data[SIZE_W-1:0];
			REG_DEV_LIMIT:   regs.deviation_limit = data[LIM_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// block idle: every reading taken and the frame-end sequence long finished
	task automatic settle_block();
		s_axis_tvalid = 1'b0;
		while (pending_readings.size() != 0) @(posedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic pick_settings();
		int unsigned eff;
		if ($urandom_range(0, 3) != 0) write_reg(REG_ROW_LEN, reg_value($urandom_range(0, 9)));
		eff = clamp_dim(regs.row_len);
		if ($urandom_range(0, 3) != 0) write_reg(REG_ROI_LEFT, reg_value($urandom_range(0, eff)));
		if ($urandom_range(0, 3) != 0) write_reg(REG_ROI_TOP, reg_value($urandom_range(0, 3)));
		if ($urandom_range(0, 3) != 0)
			write_reg(REG_ROI_COLS, reg_value($urandom_range(0, eff + 1)));
		if ($urandom_range(0, 3) != 0) write_reg(REG_ROI_ROWS, reg_value($urandom_range(0, 4)));
		if ($urandom_range(0, 3) != 0) begin
			case ($urandom_range(0, 3))
				0:       write_reg(REG_DEV_LIMIT, 16'd0);
				3:       write_reg(REG_DEV_LIMIT, reg_value($urandom_range(0, 65535)));
				default: write_reg(REG_DEV_LIMIT, reg_value($urandom_range(0, 300)));
			endcase
		end
		if ($urandom_range(0, 15) == 0)
			write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, reg_value(0));
		tx_steady = $urandom_range(0, 4) == 0;
		rx_steady = $urandom_range(0, 4) == 0;
		settings++;
	endtask

	// Mostly whole rows that sweep across the rectangle, otherwise a short ragged burst.
	// Pixels cluster around a base value so the variance gate goes both ways.
	task automatic send_frame();
		int unsigned fw, span, len;
		logic [15:0] base, spread, pix;
		logic [31:0] v;
		reading_t    none;
		fw   = clamp_dim(regs.row_len);
		span = regs.roi_top + clamp_dim(regs.roi_rows) + 1;
		if ($urandom_range(0, 3) != 0 && fw * span <= 96)
			len = fw * $urandom_range((span > 2) ? span - 2 : 1, span);
		else
			len = $urandom_range(1, 24);
		v    = $urandom;
		base = v[15:0];
		case ($urandom_range(0, 3))
			0:       spread = 16'h0000;
			1:       spread = 16'h0007;
			2:       spread = 16'h00FF;
			default: spread = 16'hFFFF;
		endcase
		none = '0;
		for (int unsigned i = 0; i < len; i++) begin
			v   = $urandom;
			pix = base ^ (v[15:0] & spread);
			if ($urandom_range(0, 19) == 0) pix = v[31:16];
			send_pixel(pix, i == len - 1, 1'b0, none);
		end
	endtask

	initial begin : rx_side
		int hold;
		hold          = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_steady) begin
				m_axis_tready = 1'b1;
			end else if (hold > 0) begin
				m_axis_tready = 1'b0;
				hold--;
			end else begin
				m_axis_tready = 1'b1;
				if ($urandom_range(0, 2) == 0) hold = pause_len();
			end
		end
	end

	always @(posedge clk) begin : reading_check
		reading_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.avg      = m_axis_tdata[15:0];
			got.raw      = m_axis_tdata[31:16];
			got.rejected = m_axis_tuser;
			if (pending_readings.size() == 0) begin
				$error("reading with none pending: avg_reading %0d raw_mean %0d rejected %0d",
					got.avg, got.raw, got.rejected);
				mismatches++;
			end else begin
				want = pending_readings.pop_front();
				readings_seen++;
				if (want.rejected) rejects_seen++;
				if (got.avg !== want.avg) begin
					$error("avg_reading: expected %0d, got %0d", want.avg, got.avg);
					mismatches++;
				end
				if (got.rejected !== want.rejected) begin
					$error("rejected: expected %0d, got %0d", want.rejected, got.rejected);
					mismatches++;
				end
				if (got.raw !== want.raw) begin
					$error("raw_mean: expected %0d, got %0d", want.raw, got.raw);
					mismatches++;
				end
			end
		end
	end

	initial begin : stimulus
		row_t     script[$];
		int       rand_pix0, rand_frames0;

		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = REG_ROW_LEN;
		cfg_data      = '0;
		tx_steady     = 1'b0;
		rx_steady     = 1'b0;
		mismatches    = 0;
		readings_seen = 0;
		rejects_seen  = 0;
		pix_sent      = 0;
		frames_sent   = 0;
		settings      = 1;
		regs = '{row_len: RST_ROW_LEN, roi_left: RST_ROI_LEFT, roi_top: RST_ROI_TOP,
			roi_cols: RST_ROI_COLS, roi_rows: RST_ROI_ROWS, deviation_limit: RST_DEV_LIMIT};
		col_pos = 0;
		row_pos = 0;
		acc_sum = '0;
		acc_sq  = '0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: a lone pixel at the origin is outside the rectangle
		script.push_back(known_row(16'h1234, 16'd0, 1'b0, 16'd0));
		// 2x1 rectangle filling a 2-pixel row, zero limit; spare indexes must be ignored
		script.push_back(reg_row(REG_ROW_LEN, 16'd2));
		script.push_back(reg_row(REG_ROI_LEFT, 16'd0));
		script.push_back(reg_row(REG_ROI_TOP, 16'd0));
		script.push_back(reg_row(REG_ROI_COLS, 16'd2));
		script.push_back(reg_row(REG_ROI_ROWS, 16'd1));
		script.push_back(reg_row(REG_DEV_LIMIT, 16'd0));
		script.push_back(reg_row(REG_SPARE_6, 16'hFFFF));
		script.push_back(reg_row(REG_SPARE_7, 16'hFFFF));
		script.push_back(pix_row(16'hFFFF, 1'b0));
		script.push_back(known_row(16'h0000, 16'd0, 1'b1, 16'd32767));
		// flat full-scale frame: zero variance passes a zero limit
		script.push_back(pix_row(16'hFFFF, 1'b0));
		script.push_back(known_row(16'hFFFF, 16'd65535, 1'b0, 16'd65535));
		script.push_back(reg_row(REG_DEV_LIMIT, 16'hFFFF));
		script.push_back(pix_row(16'hFFFF, 1'b0));
		script.push_back(pix_row(16'h0000, 1'b1));
		// rows below the rectangle must not count
		script.push_back(pix_row(16'h8000, 1'b0));
		script.push_back(pix_row(16'h0001, 1'b0));
		script.push_back(pix_row(16'h5555, 1'b0));
		script.push_back(pix_row(16'hAAAA, 1'b0));
		script.push_back(pix_row(16'h00FF, 1'b0));
		script.push_back(pix_row(16'hFF00, 1'b1));
		// zero row length and zero column count both act as one
		script.push_back(reg_row(REG_ROW_LEN, 16'd0));
		script.push_back(reg_row(REG_ROI_TOP, 16'd1));
		script.push_back(reg_row(REG_ROI_COLS, 16'd0));
		script.push_back(reg_row(REG_ROI_ROWS, 16'd2));
		script.push_back(reg_row(REG_DEV_LIMIT, 16'd3));
		script.push_back(pix_row(16'h0100, 1'b0));
		script.push_back(pix_row(16'h0104, 1'b0));
		script.push_back(pix_row(16'h0108, 1'b1));
		// oversized row length and column count clamp to the maximum, zero rows to one;
		// upper data bits beyond each register are dropped
		script.push_back(reg_row(REG_ROW_LEN, 16'hFFFF));
		script.push_back(reg_row(REG_ROI_LEFT, 16'hFC00));
		script.push_back(reg_row(REG_ROI_TOP, 16'd0));
		script.push_back(reg_row(REG_ROI_COLS, 16'h07FF));
		script.push_back(reg_row(REG_ROI_ROWS, 16'd0));
		script.push_back(reg_row(REG_DEV_LIMIT, 16'd0));
		script.push_back(pix_row(16'hFFFF, 1'b0));
		script.push_back(pix_row(16'hFFFF, 1'b0));
		script.push_back(pix_row(16'h7FFF, 1'b1));

		settle_block();
		foreach (script[i]) begin
			if (script[i].kind == ROW_REG) begin
				if (i > 0 && script[i-1].kind == ROW_PIX) begin
					settle_block();
					settings++;
				end
				write_reg(script[i].idx, script[i].data);
			end else begin
				send_pixel(script[i].pix, script[i].last, script[i].typed, script[i].want);
			end
		end

		rand_pix0    = pix_sent;
		rand_frames0 = frames_sent;
		while (pix_sent - rand_pix0 < 500 || frames_sent - rand_frames0 < 40) begin
			settle_block();
			pick_settings();
			repeat ($urandom_range(1, 4)) send_frame();
		end

		settle_block();
		$display("%0d pixels in %0d frames over %0d register settings; %0d readings checked, %0d gated",
			pix_sent, frames_sent, settings, readings_seen, rejects_seen);
		if (mismatches == 0 && pending_readings.size() == 0) begin
			$display("[roi_mean_variance_gate_unit] OK");
		end else begin
			$display("[roi_mean_variance_gate_unit] ERROR");
		end
		$finish;
	end

endmodule
